FILE: src/nearest_match_line_cross_counter_defines.svh
// assertion macros shared by the nearest match line cross counter
`ifndef NEAREST_MATCH_LINE_CROSS_COUNTER_DEFINES_SVH
`define NEAREST_MATCH_LINE_CROSS_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define NMLCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define NMLCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NMLCC_ASSERT(label, clk, rst, prop, msg)
`define NMLCC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: src/nmlcc_pkg.sv
// types, constants and helpers of the nearest match line cross counter
package nmlcc_pkg;

  localparam int COORD_BITS      = 12;
  localparam int CENT_W          = COORD_BITS + 1;
  localparam int SQ_W            = 2 * CENT_W;
  localparam int DIST_W          = SQ_W + 1;
  localparam int END_W           = 14;
  localparam int PT_W            = 15;
  localparam int CFG_W           = 26;
  localparam int CFG_IDX_W       = 3;
  localparam int MATCH_IDX_W     = 6;
  localparam int TOTAL_W         = 32;
  localparam int STEP_W          = 3;
  localparam int MAX_OBJECTS_DEF = 64;

  localparam logic [CFG_W-1:0] MAX_DIST_SQ_RESET = CFG_W'(2500);

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_END_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_END_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_END_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_END_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST_SQ = 3'd6;

  // side test selects within one segment: point triple (p, q, r)
  localparam logic [1:0] SIDE_ABO = 2'd0;
  localparam logic [1:0] SIDE_ABE = 2'd1;
  localparam logic [1:0] SIDE_OEA = 2'd2;
  localparam logic [1:0] SIDE_OEB = 2'd3;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_w;
    logic [COORD_BITS-1:0] rect_h;
  } item_t;

  typedef struct packed {
    logic                   match_found;
    logic [MATCH_IDX_W-1:0] match_index;
    logic                   crossed;
    logic [TOTAL_W-1:0]     total_count;
  } result_t;

  typedef struct packed {
    logic [CENT_W-1:0] x;
    logic [CENT_W-1:0] y;
  } cent_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } pt_t;

  typedef struct packed {
    cent_t             cent;
    logic [DIST_W-1:0] dist_sq;
  } best_t;

  typedef struct packed {
    logic              vld;
    logic [STEP_W-1:0] tag;
    logic              pos;
  } side_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CROSS,
    ST_WAIT,
    ST_DONE
  } state_t;

  function automatic cent_t centroid(item_t it);
    cent_t c;
    c.x = CENT_W'(it.rect_x) + CENT_W'(it.rect_w >> 1);
    c.y = CENT_W'(it.rect_y) + CENT_W'(it.rect_h >> 1);
    return c;
  endfunction

  function automatic logic signed [PT_W-1:0] upt(logic [CENT_W-1:0] v);
    return $signed(PT_W'(v));
  endfunction

endpackage

FILE: src/nmlcc_ram.sv
// generic single write port ram with registered read
module nmlcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/nmlcc_dist.sv
// distance pipeline: squares a stored centroid against the query and keeps the nearest
module nmlcc_dist #(
  parameter int AW = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue,
  input  logic [AW-1:0]         issue_idx,
  input  nmlcc_pkg::cent_t      rdata,
  input  nmlcc_pkg::cent_t      qc,
  output nmlcc_pkg::best_t      best,
  output logic [AW-1:0]         best_idx,
  output logic                  pending
);
  import nmlcc_pkg::*;

  logic              vld1;
  logic              first1;
  logic [AW-1:0]     idx1;
  logic              vld2;
  logic              first2;
  logic [AW-1:0]     idx2;
  cent_t             cent2;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic [CENT_W:0]   dx;
  logic [CENT_W:0]   dy;
  logic [CENT_W-1:0] adx;
  logic [CENT_W-1:0] ady;
  logic [DIST_W-1:0] d;

  // ram data lines up with stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= issue;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= issue_idx;
    first1 <= (issue_idx == '0);
  end

  always_comb begin
    dx  = {1'b0, rdata.x} - {1'b0, qc.x};
    dy  = {1'b0, rdata.y} - {1'b0, qc.y};
    adx = dx[CENT_W] ? CENT_W'(-dx) : dx[CENT_W-1:0];
    ady = dy[CENT_W] ? CENT_W'(-dy) : dy[CENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    sqx    <= adx * adx;
    sqy    <= ady * ady;
    cent2  <= rdata;
    idx2   <= idx1;
    first2 <= first1;
  end

  assign d = DIST_W'(sqx) + DIST_W'(sqy);

  // strict compare keeps the lowest slot on ties
  always_ff @(posedge clk) begin
    if (vld2 && (first2 || (d < best.dist_sq))) begin
      best.dist_sq <= d;
      best.cent    <= cent2;
      best_idx     <= idx2;
    end
  end

  assign pending = vld1 | vld2;

endmodule

FILE: src/nmlcc_side.sv
// two stage cross product unit: strict positive side of r against segment p to q
module nmlcc_side (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       vld,
  input  logic [nmlcc_pkg::STEP_W-1:0] tag,
  input  nmlcc_pkg::pt_t             p,
  input  nmlcc_pkg::pt_t             q,
  input  nmlcc_pkg::pt_t             r,
  output nmlcc_pkg::side_res_t       res
);
  import nmlcc_pkg::*;

  logic signed [PT_W:0]       dqx;
  logic signed [PT_W:0]       dqy;
  logic signed [PT_W:0]       drx;
  logic signed [PT_W:0]       dry;
  logic signed [2*PT_W+1:0]   m1;
  logic signed [2*PT_W+1:0]   m2;
  logic                       vld1;
  logic [STEP_W-1:0]          tag1;
  logic signed [2*PT_W+2:0]   c;
  logic                       vld2;
  logic [STEP_W-1:0]          tag2;
  logic                       pos2;

  always_comb begin
    dqx = q.x - p.x;
    dqy = q.y - p.y;
    drx = r.x - p.x;
    dry = r.y - p.y;
  end

  always_ff @(posedge clk) begin
    m1   <= dqx * dry;
    m2   <= dqy * drx;
    tag1 <= tag;
  end

  assign c = {m1[2*PT_W+1], m1} - {m2[2*PT_W+1], m2};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= vld;
      vld2 <= vld1;
    end
  end

  // zero counts as the negative side
  always_ff @(posedge clk) begin
    tag2 <= tag1;
    pos2 <= !c[2*PT_W+2] && (c != '0);
  end

  assign res = '{vld: vld2, tag: tag2, pos: pos2};

endmodule

FILE: src/nearest_match_line_cross_counter.sv
// top level of the nearest match line cross counter
//
// an item is taken at a clock edge with start high and busy low. clear and load items
// take effect at the accepting edge and never raise busy; a load into a full store is
// dropped. a query raises busy, walks the stored centroids one per cycle through the
// single read port of the centroid ram, then runs eight side tests through one shared
// cross product unit, passing the scan, drain, cross, wait and done states (an empty
// store goes straight to done); the result strobe (done) is registered from done state.
// busy falls in the strobe cycle, so the next item can be taken at the edge that ends
// it. result holds the result while done is high, which is for a single cycle, and the
// receiver cannot hold it off. configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while busy is low; the block does not enforce it.
`include "nearest_match_line_cross_counter_defines.svh"
module nearest_match_line_cross_counter #(
  parameter int MAX_OBJECTS = nmlcc_pkg::MAX_OBJECTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  nmlcc_pkg::item_t              item,
  output logic                          done,
  output nmlcc_pkg::result_t            result,
  input  logic                          cfg_we,
  input  logic [nmlcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nmlcc_pkg::CFG_W-1:0]   cfg_data
);
  import nmlcc_pkg::*;

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  // configuration
  logic [COORD_BITS-1:0]   center_x;
  logic [COORD_BITS-1:0]   center_y;
  logic signed [END_W-1:0] right_end_x;
  logic signed [END_W-1:0] right_end_y;
  logic signed [END_W-1:0] left_end_x;
  logic signed [END_W-1:0] left_end_y;
  logic [CFG_W-1:0]        max_distance_sq;

  // control and state
  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              take_query;
  logic              scan_en;
  logic              side_en;
  logic              finish;
  logic [CW-1:0]     ref_count;
  logic [CW-1:0]     scan_idx;
  logic              scan_last;
  logic [STEP_W-1:0] step;
  logic [7:0]        side_bits;
  logic              q_found;
  cent_t             qc;
  cent_t             item_cent;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic              counted;
  logic              hit;

  // ram and units
  logic              ram_we;
  logic [CENT_W*2-1:0] ram_rdata;
  best_t             best;
  logic [AW-1:0]     best_idx;
  logic              dist_pending;
  side_res_t         side_res;
  pt_t               pa;
  pt_t               pb;
  pt_t               po;
  pt_t               pe;
  pt_t               sp;
  pt_t               sq;
  pt_t               sr;

  assign accept     = start && !busy;
  assign take_query = accept && (item.kind == KIND_QUERY);
  assign item_cent  = centroid(item);
  assign scan_last  = (CW'(scan_idx + 1'b1) == ref_count);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      right_end_x     <= '0;
      right_end_y     <= '0;
      left_end_x      <= '0;
      left_end_y      <= '0;
      max_distance_sq <= MAX_DIST_SQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:    center_x        <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y:    center_y        <= cfg_data[COORD_BITS-1:0];
        CFG_RIGHT_END_X: right_end_x     <= $signed(cfg_data[END_W-1:0]);
        CFG_RIGHT_END_Y: right_end_y     <= $signed(cfg_data[END_W-1:0]);
        CFG_LEFT_END_X:  left_end_x      <= $signed(cfg_data[END_W-1:0]);
        CFG_LEFT_END_Y:  left_end_y      <= $signed(cfg_data[END_W-1:0]);
        CFG_MAX_DIST_SQ: max_distance_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (item.kind == KIND_QUERY)) begin
          state_next = (ref_count != '0) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dist_pending) begin
          state_next = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (step == STEP_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (side_res.vld && (side_res.tag == STEP_LAST)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    side_en = 1'b0;
    finish  = 1'b0;
    unique case (state)
      ST_IDLE:  busy    = 1'b0;
      ST_SCAN:  scan_en = 1'b1;
      ST_CROSS: side_en = 1'b1;
      ST_DONE:  finish  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store fill count; clear and load act in the accepting cycle
  assign ram_we = accept && (item.kind == KIND_LOAD) && (ref_count < CW'(MAX_OBJECTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
    end else if (accept && (item.kind == KIND_CLEAR)) begin
      ref_count <= '0;
    end else if (ram_we) begin
      ref_count <= CW'(ref_count + 1'b1);
    end
  end

  // query latch and walk counters
  always_ff @(posedge clk) begin
    if (accept && (item.kind == KIND_QUERY)) begin
      qc      <= item_cent;
      q_found <= (ref_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      step     <= '0;
    end else begin
      if (accept) begin
        scan_idx <= '0;
      end else if (scan_en) begin
        scan_idx <= CW'(scan_idx + 1'b1);
      end
      if (side_en) begin
        step <= STEP_W'(step + 1'b1);
      end else begin
        step <= '0;
      end
    end
  end

  nmlcc_ram #(
    .WIDTH(2 * CENT_W),
    .DEPTH(MAX_OBJECTS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ref_count[AW-1:0]),
    .wdata(item_cent),
    .re   (scan_en),
    .raddr(scan_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  nmlcc_dist #(
    .AW(AW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .issue    (scan_en),
    .issue_idx(scan_idx[AW-1:0]),
    .rdata    (cent_t'(ram_rdata)),
    .qc       (qc),
    .best     (best),
    .best_idx (best_idx),
    .pending  (dist_pending)
  );

  // operands of the side tests: query a, match b, shared start o, segment end e
  always_comb begin
    pa.x = upt(qc.x);
    pa.y = upt(qc.y);
    pb.x = upt(best.cent.x);
    pb.y = upt(best.cent.y);
    po.x = upt(CENT_W'(center_x));
    po.y = upt(CENT_W'(center_y));
    pe.x = step[2] ? PT_W'(left_end_x) : PT_W'(right_end_x);
    pe.y = step[2] ? PT_W'(left_end_y) : PT_W'(right_end_y);
    unique case (step[1:0])
      SIDE_ABO: begin
        sp = pa;
        sq = pb;
        sr = po;
      end
      SIDE_ABE: begin
        sp = pa;
        sq = pb;
        sr = pe;
      end
      SIDE_OEA: begin
        sp = po;
        sq = pe;
        sr = pa;
      end
      SIDE_OEB: begin
        sp = po;
        sq = pe;
        sr = pb;
      end
      default: begin
        sp = pa;
        sq = pb;
        sr = po;
      end
    endcase
  end

  nmlcc_side u_side (
    .clk(clk),
    .rst(rst),
    .vld(side_en),
    .tag(step),
    .p  (sp),
    .q  (sq),
    .r  (sr),
    .res(side_res)
  );

  always_ff @(posedge clk) begin
    if (side_res.vld) begin
      side_bits[side_res.tag] <= side_res.pos;
    end
  end

  // segments cross when each has its ends on opposite sides of the other
  assign hit = ((side_bits[0] != side_bits[1]) && (side_bits[2] != side_bits[3]))
            || ((side_bits[4] != side_bits[5]) && (side_bits[6] != side_bits[7]));
  assign counted = q_found && hit && (best.dist_sq < DIST_W'(max_distance_sq));
  assign total_next = (counted && (total != '1)) ? TOTAL_W'(total + 1'b1) : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= finish;
      if (finish) begin
        total <= total_next;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (finish) begin
      result.match_found <= q_found;
      result.match_index <= q_found ? MATCH_IDX_W'(best_idx) : '0;
      result.crossed     <= counted;
      result.total_count <= total_next;
    end
  end

  `NMLCC_ASSERT(a_done_single, clk, rst, done |=> !done, "strobe longer than one cycle")
  `NMLCC_ASSERT(a_query_busy, clk, rst, take_query |=> busy, "query accepted without busy")
  `NMLCC_ASSERT(a_count_bound, clk, rst, ref_count <= CW'(MAX_OBJECTS), "count beyond depth")
  `NMLCC_ASSERT(a_total_mono, clk, rst, 1'b1 |=> (total >= $past(total)), "total went down")
  `NMLCC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the nearest match line cross counter
`timescale 1ns / 1ps
module tb_top;
  import nmlcc_pkg::*;

  localparam int          SLOTS       = MAX_OBJECTS_DEF;
  localparam int          CENT_MAX    = 4095 + 2047;
  localparam int          ITEM_TARGET = 1150;
  localparam int          PHASES      = 8;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] DIST_MAX = '1;

  // one row of the directed table: the beat, and a hand-typed result where one is given
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } dir_row_t;

  // anchor of a reference placed near a counting segment: point on the line plus offset
  typedef struct {
    int px;
    int py;
    int ox;
    int oy;
  } anchor_t;

  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // query on an empty store right after reset
    '{'{KIND_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, '{1'b0, 6'd0, 1'b0, 32'd0}},
    // unused kind with every field at its top, ignored
    '{'{KIND_UNUSED, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b0, '0},
    '{'{KIND_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0},
    '{'{KIND_LOAD, 12'd110, 12'd100, 12'd0, 12'd0}, 1'b0, '0},
    // odd sizes round down, lands on the same centroid as the slot before
    '{'{KIND_LOAD, 12'd60, 12'd80, 12'd101, 12'd41}, 1'b0, '0},
    '{'{KIND_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b0, '0},
    '{'{KIND_LOAD, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0},
    // tie between two slots, crosses the vertical segment
    '{'{KIND_QUERY, 12'd90, 12'd100, 12'd1, 12'd1}, 1'b0, '0},
    // distance exactly at the limit, not counted
    '{'{KIND_QUERY, 12'd60, 12'd100, 12'd0, 12'd0}, 1'b0, '0},
    // just under the limit
    '{'{KIND_QUERY, 12'd61, 12'd91, 12'd0, 12'd0}, 1'b0, '0},
    '{'{KIND_QUERY, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b0, '0},
    '{'{KIND_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0},
    // query centroid on the segment, zero cross product
    '{'{KIND_QUERY, 12'd100, 12'd100, 12'd0, 12'd0}, 1'b0, '0},
    // both ends on one side
    '{'{KIND_QUERY, 12'd111, 12'd100, 12'd0, 12'd0}, 1'b0, '0},
    '{'{KIND_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0},
    // empty again, total must carry over
    '{'{KIND_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  item_t              item;
  logic               done;
  result_t            result;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  // predictor state
  cent_t              ref_cent [SLOTS];
  int                 ref_fill;
  logic [TOTAL_W-1:0] cross_total;
  logic [11:0]        line_cx;
  logic [11:0]        line_cy;
  logic signed [13:0] line_rx;
  logic signed [13:0] line_ry;
  logic signed [13:0] line_lx;
  logic signed [13:0] line_ly;
  logic [CFG_W-1:0]   dist_limit;

  result_t            expected_matches [$];
  anchor_t            anchors [$];
  logic [CFG_W-1:0]   reg_plan [7];
  int                 item_count;
  int                 errors;
  bit                 no_gaps;

  nearest_match_line_cross_counter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #15ms;
    $display("FAIL nearest_match_line_cross_counter");
    $finish;
  end

  // strict side test: a zero cross product falls on the negative side
  function automatic bit on_plus_side(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
    return ((qx - px) * (ry - py) - (qy - py) * (rx - px)) > 0;
  endfunction

  function automatic bit segments_straddle(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy, longint dx, longint dy);
    return (on_plus_side(ax, ay, bx, by, cx, cy) != on_plus_side(ax, ay, bx, by, dx, dy)) &&
           (on_plus_side(cx, cy, dx, dy, ax, ay) != on_plus_side(cx, cy, dx, dy, bx, by));
  endfunction

  // advance the predictor by one beat; returns 1 when the beat yields a result
  function automatic bit match_and_count(item_t it, output result_t res);
    cent_t  q;
    cent_t  b;
    longint dx;
    longint dy;
    longint d;
    longint best_d;
    int     best;
    bit     hit;
    bit     counted;
    q.x = CENT_W'(it.rect_x) + CENT_W'(it.rect_w >> 1);
    q.y = CENT_W'(it.rect_y) + CENT_W'(it.rect_h >> 1);
    res = '0;
    case (it.kind)
      KIND_CLEAR: begin
        ref_fill = 0;
        return 1'b0;
      end
      KIND_LOAD: begin
        // full store drops the load
        if (ref_fill < SLOTS) begin
          ref_cent[ref_fill] = q;
          ref_fill++;
        end
        return 1'b0;
      end
      KIND_QUERY: ;
      default: return 1'b0;
    endcase
    res.total_count = cross_total;
    if (ref_fill == 0) return 1'b1;
    best   = 0;
    best_d = 0;
    for (int i = 0; i < ref_fill; i++) begin
      dx = longint'(ref_cent[i].x) - longint'(q.x);
      dy = longint'(ref_cent[i].y) - longint'(q.y);
      d  = dx * dx + dy * dy;
      // strict compare keeps the lowest slot on ties
      if (i == 0 || d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    b   = ref_cent[best];
    hit = segments_straddle(q.x, q.y, b.x, b.y, line_cx, line_cy,
                            longint'(line_rx), longint'(line_ry)) ||
          segments_straddle(q.x, q.y, b.x, b.y, line_cx, line_cy,
                            longint'(line_lx), longint'(line_ly));
    counted = hit && (best_d < longint'(dist_limit));
    if (counted && cross_total != '1) cross_total++;
    res.match_found = 1'b1;
    res.match_index = MATCH_IDX_W'(best);
    res.crossed     = counted;
    res.total_count = cross_total;
    return 1'b1;
  endfunction

  // one beat through the start/busy handshake, with a random gap in front
  task automatic issue_item(item_t it, bit typed, result_t typed_res);
    int unsigned gap;
    result_t     pred;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    // busy sampled before the edge updates it
    do @(posedge clk); while (busy);
    item_count++;
    if (match_and_count(it, pred))
      expected_matches.insert(expected_matches.size(), typed ? typed_res : pred);
  endtask

  // drop start and let every outstanding query finish, plus load/clear latency
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write registers 0 .. count-1 from reg_plan, mirror them into the predictor
  task automatic program_regs(int count);
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      idx = CFG_IDX_W'(i);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_plan[idx];
      case (idx)
        CFG_CENTER_X:    line_cx    = reg_plan[idx][11:0];
        CFG_CENTER_Y:    line_cy    = reg_plan[idx][11:0];
        CFG_RIGHT_END_X: line_rx    = reg_plan[idx][13:0];
        CFG_RIGHT_END_Y: line_ry    = reg_plan[idx][13:0];
        CFG_LEFT_END_X:  line_lx    = reg_plan[idx][13:0];
        CFG_LEFT_END_Y:  line_ly    = reg_plan[idx][13:0];
        CFG_MAX_DIST_SQ: dist_limit = reg_plan[idx];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int clamp_cent(int v);
    return (v < 0) ? 0 : (v > CENT_MAX) ? CENT_MAX : v;
  endfunction

  // pick a rectangle whose centroid is exactly (cx, cy), each clamped to the centroid range
  function automatic item_t rect_at(logic [1:0] kind, int cx, int cy);
    item_t it;
    int    c;
    int    half;
    c    = clamp_cent(cx);
    half = $urandom_range((c < 2047) ? c : 2047, (c > 4095) ? c - 4095 : 0);
    it.kind   = kind;
    it.rect_w = 12'(2 * half + $urandom_range(0, 1));
    it.rect_x = 12'(c - half);
    c    = clamp_cent(cy);
    half = $urandom_range((c < 2047) ? c : 2047, (c > 4095) ? c - 4095 : 0);
    it.rect_h = 12'(2 * half + $urandom_range(0, 1));
    it.rect_y = 12'(c - half);
    return it;
  endfunction

  function automatic item_t rect_any(logic [1:0] kind);
    item_t it;
    it.kind   = kind;
    it.rect_x = 12'($urandom);
    it.rect_y = 12'($urandom);
    it.rect_w = 12'($urandom);
    it.rect_h = 12'($urandom);
    return it;
  endfunction

  // point somewhere on one of the two counting segments, offset a little
  function automatic anchor_t anchor_near_line();
    anchor_t a;
    int      t;
    int      ex;
    int      ey;
    t  = $urandom_range(0, 1000);
    ex = $urandom_range(0, 1) ? int'(line_rx) : int'(line_lx);
    ey = (ex == int'(line_rx)) ? int'(line_ry) : int'(line_ly);
    a.px = int'(line_cx) + (ex - int'(line_cx)) * t / 1000;
    a.py = int'(line_cy) + (ey - int'(line_cy)) * t / 1000;
    a.ox = int'($urandom_range(0, 80)) - 40;
    a.oy = int'($urandom_range(0, 80)) - 40;
    return a;
  endfunction

  // one store cycle: optional clear, a batch of references, a batch of queries
  task automatic run_batch();
    int      nload;
    int      nquery;
    int      pick;
    anchor_t a;
    item_t   it;
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) != 0) begin
      issue_item(rect_any(KIND_CLEAR), 1'b0, '0);
      anchors.delete();
    end
    pick = $urandom_range(0, 9);
    // mostly small stores, some that run over the top
    nload = (pick == 0) ? 0 : (pick <= 2) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    repeat (nload) begin
      if ($urandom_range(0, 3) == 0) begin
        it = rect_any(KIND_LOAD);
      end else begin
        a  = anchor_near_line();
        it = rect_at(KIND_LOAD, a.px + a.ox, a.py + a.oy);
        anchors.insert(anchors.size(), a);
      end
      issue_item(it, 1'b0, '0);
    end
    nquery = $urandom_range(1, 10);
    repeat (nquery) begin
      if ($urandom_range(0, 29) == 0)
        issue_item(rect_any(KIND_UNUSED), 1'b0, '0);
      if (anchors.size() == 0 || $urandom_range(0, 4) == 0) begin
        it = rect_any(KIND_QUERY);
      end else begin
        // mirror a reference across its line point so the pair straddles the segment
        a  = anchors[$urandom_range(0, anchors.size() - 1)];
        it = rect_at(KIND_QUERY, a.px - a.ox + int'($urandom_range(0, 6)) - 3,
                     a.py - a.oy + int'($urandom_range(0, 6)) - 3);
      end
      issue_item(it, 1'b0, '0);
    end
  endtask

  // result checker: every strobe must match the oldest outstanding query
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_matches.size() == 0) begin
        $error("result strobe with no query outstanding");
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (result.match_found !== want.match_found) begin
          $error("match_found expected %0d got %0d", want.match_found, result.match_found);
          errors++;
        end
        if (result.match_index !== want.match_index) begin
          $error("match_index expected %0d got %0d", want.match_index, result.match_index);
          errors++;
        end
        if (result.crossed !== want.crossed) begin
          $error("crossed expected %0d got %0d", want.crossed, result.crossed);
          errors++;
        end
        if (result.total_count !== want.total_count) begin
          $error("total_count expected %0d got %0d", want.total_count, result.total_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int ph_end;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    errors     = 0;
    item_count = 0;
    no_gaps    = 1'b0;
    ref_fill   = 0;
    cross_total = '0;
    line_cx    = '0;
    line_cy    = '0;
    line_rx    = '0;
    line_ry    = '0;
    line_lx    = '0;
    line_ly    = '0;
    dist_limit = MAX_DIST_SQ_RESET;
    foreach (ref_cent[i]) ref_cent[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: vertical segment at x = 100, limit left at its reset value
    reg_plan[CFG_CENTER_X]    = CFG_W'(100);
    reg_plan[CFG_CENTER_Y]    = CFG_W'(0);
    reg_plan[CFG_RIGHT_END_X] = CFG_W'(100);
    reg_plan[CFG_RIGHT_END_Y] = CFG_W'(400);
    reg_plan[CFG_LEFT_END_X]  = CFG_W'(-4096);
    reg_plan[CFG_LEFT_END_Y]  = CFG_W'(8191);
    program_regs(6);
    foreach (DIRECTED[r])
      issue_item(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].want);
    drain();

    // random part, one register setting per phase; the first two are the extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          reg_plan[CFG_CENTER_X]    = CFG_W'(0);
          reg_plan[CFG_CENTER_Y]    = CFG_W'(4095);
          reg_plan[CFG_RIGHT_END_X] = CFG_W'(8191);
          reg_plan[CFG_RIGHT_END_Y] = CFG_W'(-4096);
          reg_plan[CFG_LEFT_END_X]  = CFG_W'(-4096);
          reg_plan[CFG_LEFT_END_Y]  = CFG_W'(8191);
          reg_plan[CFG_MAX_DIST_SQ] = DIST_MAX;
        end
        1: begin
          reg_plan[CFG_CENTER_X]    = CFG_W'(4095);
          reg_plan[CFG_CENTER_Y]    = CFG_W'(0);
          reg_plan[CFG_RIGHT_END_X] = CFG_W'(8191);
          reg_plan[CFG_RIGHT_END_Y] = CFG_W'(8191);
          reg_plan[CFG_LEFT_END_X]  = CFG_W'(-4096);
          reg_plan[CFG_LEFT_END_Y]  = CFG_W'(-4096);
          reg_plan[CFG_MAX_DIST_SQ] = '0;
        end
        default: begin
          reg_plan[CFG_CENTER_X]    = CFG_W'($urandom_range(0, 4095));
          reg_plan[CFG_CENTER_Y]    = CFG_W'($urandom_range(0, 4095));
          reg_plan[CFG_RIGHT_END_X] = CFG_W'(int'($urandom_range(0, 12287)) - 4096);
          reg_plan[CFG_RIGHT_END_Y] = CFG_W'(int'($urandom_range(0, 12287)) - 4096);
          reg_plan[CFG_LEFT_END_X]  = CFG_W'(int'($urandom_range(0, 12287)) - 4096);
          reg_plan[CFG_LEFT_END_Y]  = CFG_W'(int'($urandom_range(0, 12287)) - 4096);
          reg_plan[CFG_MAX_DIST_SQ] = (ph == 2) ? MAX_DIST_SQ_RESET
                                                 : CFG_W'($urandom_range(200, 15000));
        end
      endcase
      program_regs(7);
      ph_end = DIR_ROWS + (ITEM_TARGET * (ph + 1)) / PHASES;
      while (item_count < ph_end) run_batch();
      drain();
    end

    // longest query is a full store plus the tail of the cross tests
    repeat (SLOTS + 40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS nearest_match_line_cross_counter");
    end else begin
      $display("FAIL nearest_match_line_cross_counter");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/nmlcc_pkg.sv
src/nmlcc_ram.sv
src/nmlcc_dist.sv
src/nmlcc_side.sv
src/nearest_match_line_cross_counter.sv
sim/tb_top.sv
